@@ rtl/vig_pkg.sv @@
// shared types, constants and alphabet lookup functions for the 92-symbol vigenere cipher
package vig_pkg;

    localparam int KEY_MAX     = 32;
    localparam int KEY_POS_W   = $clog2(KEY_MAX);
    localparam int KEY_LEN_W   = 6;
    localparam int SYMBOLS     = 92;
    localparam int SYM_IDX_W   = 7;
    localparam int KEY_WORDS   = 4;
    localparam int APB_ADDR_W  = 6;
    localparam int APB_DATA_W  = 64;
    localparam int REG_SEL_W   = 3;
    localparam int SPECIALS    = 30;
    localparam int SPECIAL_W   = 5;

    localparam logic [7:0] CHAR_NL = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;

    // register map, one 64-bit slot each
    typedef enum logic [REG_SEL_W-1:0] {
        REG_MODE    = 3'd0,
        REG_KEY_LEN = 3'd1,
        REG_KEY0    = 3'd2,
        REG_KEY1    = 3'd3,
        REG_KEY2    = 3'd4,
        REG_KEY3    = 3'd5
    } vig_reg_t;

    // cipher direction
    typedef enum logic {
        MODE_ENCRYPT = 1'b0,
        MODE_DECRYPT = 1'b1
    } vig_mode_t;

    // configuration as seen by the datapath
    typedef struct packed {
        vig_mode_t                  mode;
        logic [KEY_LEN_W-1:0]       key_len;
        logic [KEY_MAX-1:0][7:0]    key_chars;
    } vig_cfg_t;

    typedef struct packed {
        logic                   found;
        logic [SYM_IDX_W-1:0]   idx;
    } sym_lookup_t;

    // punctuation tail of the alphabet, indexes 62 to 91
    localparam logic [7:0] SPECIAL_CHARS [SPECIALS] = '{
        8'h21, 8'h23, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C,
        8'h2D, 8'h2E, 8'h2F, 8'h3A, 8'h3B, 8'h3C, 8'h3D, 8'h3E, 8'h3F, 8'h40,
        8'h5B, 8'h5D, 8'h5E, 8'h5F, 8'h60, 8'h7B, 8'h20, 8'h7D, 8'h7E, 8'h7C
    };

    localparam int SPECIAL_BASE = 62;

    // byte to alphabet index
    function automatic sym_lookup_t symbol_index(input logic [7:0] b);
        sym_lookup_t r;
        logic [7:0]  t;
        r.found = 1'b0;
        r.idx   = '0;
        t       = '0;
        if (b >= 8'h41 && b <= 8'h5A)
        begin
            t       = b - 8'd65;
            r.found = 1'b1;
            r.idx   = t[SYM_IDX_W-1:0];
        end
        else if (b >= 8'h61 && b <= 8'h7A)
        begin
            t       = b - 8'd71;
            r.found = 1'b1;
            r.idx   = t[SYM_IDX_W-1:0];
        end
        else if (b >= 8'h30 && b <= 8'h39)
        begin
            t       = b + 8'd4;
            r.found = 1'b1;
            r.idx   = t[SYM_IDX_W-1:0];
        end
        else
        begin
            for (int i = 0; i < SPECIALS; i++)
            begin
                if (SPECIAL_CHARS[i] == b)
                begin
                    r.found = 1'b1;
                    r.idx   = SYM_IDX_W'(SPECIAL_BASE + i);
                end
            end
        end
        return r;
    endfunction

    // alphabet index to byte
    function automatic logic [7:0] symbol_char(input logic [SYM_IDX_W-1:0] idx);
        logic [7:0] r;
        logic [7:0] off;
        off = {1'b0, idx} - 8'(SPECIAL_BASE);
        if (idx < SYM_IDX_W'(26))
            r = {1'b0, idx} + 8'd65;
        else if (idx < SYM_IDX_W'(52))
            r = {1'b0, idx} + 8'd71;
        else if (idx < SYM_IDX_W'(SPECIAL_BASE))
            r = {1'b0, idx} - 8'd4;
        else if (idx < SYM_IDX_W'(SYMBOLS))
            r = SPECIAL_CHARS[off[SPECIAL_W-1:0]];
        else
            r = '0;
        return r;
    endfunction

endpackage

@@ rtl/vig_if.sv @@
// request channel interfaces for cipher input and output bytes
interface vig_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       line_start;

    modport source (output valid, output in_byte, output line_start, input ready);
    modport sink   (input valid, input in_byte, input line_start, output ready);
endinterface

interface vig_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       passed_through;

    modport source (output valid, output out_byte, output passed_through, input ready);
    modport sink   (input valid, input out_byte, input passed_through, output ready);
endinterface

@@ rtl/vig_cfg.sv @@
// apb register file holding mode, key length and key characters
module vig_cfg
    import vig_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready,
    output vig_cfg_t                cfg
);

    logic                               mode_reg;
    logic [KEY_LEN_W-1:0]               key_len_reg;
    logic [KEY_WORDS-1:0][63:0]         key_reg;
    logic                               wr_en;
    vig_reg_t                           sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign sel    = vig_reg_t'(paddr[APB_ADDR_W-1:3]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            key_len_reg <= KEY_LEN_W'(1);
            key_reg     <= '0;
        end
        else if (wr_en)
        begin
            case (sel)
                REG_MODE:    mode_reg    <= pwdata[0];
                REG_KEY_LEN: key_len_reg <= pwdata[KEY_LEN_W-1:0];
                REG_KEY0:    key_reg[0]  <= pwdata;
                REG_KEY1:    key_reg[1]  <= pwdata;
                REG_KEY2:    key_reg[2]  <= pwdata;
                REG_KEY3:    key_reg[3]  <= pwdata;
                default:     ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (sel)
            REG_MODE:    prdata = APB_DATA_W'(mode_reg);
            REG_KEY_LEN: prdata = APB_DATA_W'(key_len_reg);
            REG_KEY0:    prdata = key_reg[0];
            REG_KEY1:    prdata = key_reg[1];
            REG_KEY2:    prdata = key_reg[2];
            REG_KEY3:    prdata = key_reg[3];
            default:     prdata = '0;
        endcase
    end

    // clamp key length to 1..KEY_MAX
    always_comb
    begin
        cfg.mode      = vig_mode_t'(mode_reg);
        cfg.key_chars = key_reg;
        if (key_len_reg == '0)
            cfg.key_len = KEY_LEN_W'(1);
        else if (key_len_reg > KEY_LEN_W'(KEY_MAX))
            cfg.key_len = KEY_LEN_W'(KEY_MAX);
        else
            cfg.key_len = key_len_reg;
    end

endmodule

@@ rtl/vig_xform.sv @@
// alphabet lookup and mod-92 shift of one byte against its key character
module vig_xform
    import vig_pkg::*;
(
    input  vig_cfg_t                cfg,
    input  logic [7:0]              in_byte,
    input  logic [KEY_POS_W-1:0]    key_pos,
    output logic [7:0]              out_byte,
    output logic                    passed_through
);

    logic [7:0]             key_char;
    sym_lookup_t            key_look;
    sym_lookup_t            byte_look;
    logic [SYM_IDX_W-1:0]   kidx;
    logic [7:0]             shift;
    logic [7:0]             sum;
    logic [7:0]             wrapped;

    // key character and its index, unknown key chars shift by zero
    assign key_char  = cfg.key_chars[key_pos];
    assign key_look  = symbol_index(key_char);
    assign kidx      = key_look.found ? key_look.idx : '0;
    assign byte_look = symbol_index(in_byte);

    // add or subtract modulo 92
    assign shift   = (cfg.mode == MODE_DECRYPT) ? (8'(SYMBOLS) - {1'b0, kidx}) : {1'b0, kidx};
    assign sum     = {1'b0, byte_look.idx} + shift;
    assign wrapped = (sum >= 8'(SYMBOLS)) ? (sum - 8'(SYMBOLS)) : sum;

    // pass through newline, return and unknown bytes
    always_comb
    begin
        if (in_byte != CHAR_NL && in_byte != CHAR_CR && byte_look.found)
        begin
            out_byte       = symbol_char(wrapped[SYM_IDX_W-1:0]);
            passed_through = 1'b0;
        end
        else
        begin
            out_byte       = in_byte;
            passed_through = 1'b1;
        end
    end

endmodule

@@ rtl/vigenere_cipher_92_symbol.sv @@
// top level: key position tracking, input register, transform and result register
// an accepted input request goes through the input register and then the result register to the output channel
// throughput: one byte per cycle while out_ch.ready stays high, set by the input register feeding the result register
// the ready path is combinational from out_ch.ready through both stages
// reset: rst_n clears mode to encrypt, key length to 1, key bytes and key position to 0
// reset also empties both pipeline stages
module vigenere_cipher_92_symbol
    import vig_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    vig_in_if.sink                  in_ch,
    vig_out_if.source               out_ch,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [APB_ADDR_W-1:0]   paddr,
    input  logic [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    vig_cfg_t               cfg;
    logic [KEY_POS_W-1:0]   key_pos_reg;
    logic [KEY_POS_W-1:0]   key_pos_next;
    logic [KEY_POS_W-1:0]   use_pos;
    logic [KEY_LEN_W-1:0]   pos_inc;

    logic                   s1_valid_reg;
    logic [7:0]             s1_byte_reg;
    logic [KEY_POS_W-1:0]   s1_pos_reg;
    logic                   s2_valid_reg;
    logic [7:0]             s2_byte_reg;
    logic                   s2_passed_reg;

    logic                   in_fire;
    logic                   s1_adv;
    logic [7:0]             x_byte;
    logic                   x_passed;

    vig_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // handshake: stage 1 moves when the result register is free or drained
    assign s1_adv      = s1_valid_reg && (!s2_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || s1_adv;
    assign in_fire     = in_ch.valid && in_ch.ready;

    // key position for this byte and for the next one
    assign use_pos = (in_ch.line_start || ({1'b0, key_pos_reg} >= cfg.key_len))
                     ? '0 : key_pos_reg;
    assign pos_inc = {1'b0, use_pos} + KEY_LEN_W'(1);
    assign key_pos_next = (pos_inc >= cfg.key_len || in_ch.in_byte == CHAR_NL)
                          ? '0 : pos_inc[KEY_POS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_pos_reg <= '0;
        else if (in_fire)
            key_pos_reg <= key_pos_next;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ch.ready)
            s1_valid_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= in_ch.in_byte;
            s1_pos_reg  <= use_pos;
        end
    end

    vig_xform u_xform (
        .cfg            (cfg),
        .in_byte        (s1_byte_reg),
        .key_pos        (s1_pos_reg),
        .out_byte       (x_byte),
        .passed_through (x_passed)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_adv)
            s2_valid_reg <= 1'b1;
        else if (out_ch.ready)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_byte_reg   <= x_byte;
            s2_passed_reg <= x_passed;
        end
    end

    assign out_ch.valid          = s2_valid_reg;
    assign out_ch.out_byte       = s2_byte_reg;
    assign out_ch.passed_through = s2_passed_reg;

    // a newline always restarts the key
    a_nl_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && in_ch.in_byte == CHAR_NL |=> key_pos_reg == '0)
        else $error("key position not cleared after newline");

    // a held input stage keeps its byte
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_byte_reg))
        else $error("stalled input stage lost its byte");

    // a transformed result is never a line control byte
    a_no_ctrl_out: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_passed_reg |->
            s2_byte_reg != CHAR_NL && s2_byte_reg != CHAR_CR)
        else $error("cipher produced a line control byte");

    // the key position used for an accepted byte stays below the key length
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |-> {1'b0, use_pos} < cfg.key_len)
        else $error("key position beyond key length");

endmodule

@@ tb/tb_vigenere_cipher_92_symbol.sv @@
// testbench for the 92-symbol vigenere cipher: directed and random byte requests checked by a predictor
module tb_vigenere_cipher_92_symbol;
    timeunit 1ns;
    timeprecision 1ps;

    import vig_pkg::*;

    localparam int GAP_MAX        = 5;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 150;
    localparam int DRAIN_CYCLES   = 4;

    // alphabet in index order, backtick written as an octal escape
    localparam logic [8*SYMBOLS-1:0] ALPHABET = {
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
        "abcdefghijklmnopqrstuvwxyz",
        "0123456789",
        "!#$&'()*+,-./:;<=>?@[]^_\140{ }~|"
    };

    typedef struct {
        logic [7:0] data;
        logic       line_start;
    } text_req_t;

    typedef struct {
        logic [7:0] data;
        logic       passed;
    } cipher_res_t;

    logic                    clk;
    logic                    rst_n = 1'b0;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]   paddr = '0;
    logic [APB_DATA_W-1:0]   pwdata = '0;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    vig_in_if  in_ch ();
    vig_out_if out_ch ();

    vigenere_cipher_92_symbol DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers and the key position
    vig_mode_t             mdl_mode;
    logic [KEY_LEN_W-1:0]  mdl_key_len;
    logic [63:0]           mdl_key_regs [KEY_WORDS];
    logic [KEY_POS_W-1:0]  mdl_key_pos;

    text_req_t   pending_text [$];
    cipher_res_t expected_text [$];

    int error_count     = 0;
    int reg_error_count = 0;
    int send_gap;
    int recv_stall;
    int recv_draw;
    int hold_left;
    int hold_ticket   = 0;
    int hold_served;
    int quiet_cycles;
    bit send_no_idle  = 1'b0;
    bit recv_no_idle  = 1'b0;
    bit progress;

    text_req_t   drv_req;
    text_req_t   mon_req;
    cipher_res_t mon_res;
    cipher_res_t mon_exp;

    function automatic logic [7:0] alpha_char(input int i);
        return ALPHABET[8*(SYMBOLS-1-i) +: 8];
    endfunction

    // alphabet index of a byte, SYMBOLS when absent
    function automatic int alpha_pos(input logic [7:0] b);
        int i;
        for (i = 0; i < SYMBOLS; i++)
        begin
            if (alpha_char(i) == b)
                return i;
        end
        return SYMBOLS;
    endfunction

    // one byte through the cipher, advancing the key position
    task automatic encipher(input text_req_t req, output cipher_res_t res);
        int         len;
        int         pos;
        int         nxt;
        int         kidx;
        int         bidx;
        int         ridx;
        logic [7:0] kchar;
        len = mdl_key_len;
        if (len == 0)
            len = 1;
        if (len > KEY_MAX)
            len = KEY_MAX;
        pos = mdl_key_pos;
        if (req.line_start || pos >= len)
            pos = 0;
        kchar = mdl_key_regs[pos / 8][(pos % 8) * 8 +: 8];
        kidx  = alpha_pos(kchar);
        if (kidx == SYMBOLS)
            kidx = 0;
        bidx       = alpha_pos(req.data);
        res.data   = req.data;
        res.passed = 1'b1;
        if (req.data != CHAR_NL && req.data != CHAR_CR && bidx != SYMBOLS)
        begin
            if (mdl_mode == MODE_ENCRYPT)
                ridx = (bidx + kidx) % SYMBOLS;
            else
                ridx = (bidx + SYMBOLS - kidx) % SYMBOLS;
            res.data   = alpha_char(ridx);
            res.passed = 1'b0;
        end
        nxt = pos + 1;
        if (nxt >= len || req.data == CHAR_NL)
            nxt = 0;
        mdl_key_pos = KEY_POS_W'(nxt);
    endtask

    function automatic logic [63:0] reg_value(input vig_reg_t r);
        case (r)
            REG_MODE:    return 64'(mdl_mode);
            REG_KEY_LEN: return 64'(mdl_key_len);
            REG_KEY0:    return mdl_key_regs[0];
            REG_KEY1:    return mdl_key_regs[1];
            REG_KEY2:    return mdl_key_regs[2];
            REG_KEY3:    return mdl_key_regs[3];
            default:     return '0;
        endcase
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid      <= 1'b0;
            in_ch.in_byte    <= '0;
            in_ch.line_start <= 1'b0;
            send_gap         <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (send_gap != 0)
            begin
                in_ch.valid <= 1'b0;
                send_gap    <= send_gap - 1;
            end
            else if (pending_text.size() != 0)
            begin
                drv_req           = pending_text.pop_front();
                in_ch.valid      <= 1'b1;
                in_ch.in_byte    <= drv_req.data;
                in_ch.line_start <= drv_req.line_start;
                send_gap         <= send_no_idle ? 0 : int'($urandom_range(0, GAP_MAX));
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // result receiver with per-request stalls and long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_stall   <= 0;
            hold_left    <= 0;
            hold_served  <= 0;
        end
        else if (hold_served != hold_ticket)
        begin
            hold_served  <= hold_ticket;
            hold_left    <= HOLD_CYCLES;
            out_ch.ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left    <= hold_left - 1;
            out_ch.ready <= (hold_left == 1);
        end
        else if (recv_stall != 0)
        begin
            recv_stall   <= recv_stall - 1;
            out_ch.ready <= (recv_stall == 1);
        end
        else if (out_ch.valid && out_ch.ready)
        begin
            recv_draw     = recv_no_idle ? 0 : int'($urandom_range(0, GAP_MAX));
            recv_stall   <= recv_draw;
            out_ch.ready <= (recv_draw == 0);
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    // monitor: predicts on accepted requests, checks accepted results, watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mdl_mode    = MODE_ENCRYPT;
            mdl_key_len = KEY_LEN_W'(1);
            foreach (mdl_key_regs[k])
                mdl_key_regs[k] = '0;
            mdl_key_pos  = '0;
            quiet_cycles = 0;
            expected_text.delete();
        end
        else
        begin
            progress = 1'b0;
            if (psel && penable && pready)
                progress = 1'b1;
            // register write
            if (psel && penable && pwrite && pready)
            begin
                case (vig_reg_t'(paddr[APB_ADDR_W-1:3]))
                    REG_MODE:    mdl_mode = vig_mode_t'(pwdata[0]);
                    REG_KEY_LEN: mdl_key_len = pwdata[KEY_LEN_W-1:0];
                    REG_KEY0:    mdl_key_regs[0] = pwdata;
                    REG_KEY1:    mdl_key_regs[1] = pwdata;
                    REG_KEY2:    mdl_key_regs[2] = pwdata;
                    REG_KEY3:    mdl_key_regs[3] = pwdata;
                    default:     ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                mon_req.data       = in_ch.in_byte;
                mon_req.line_start = in_ch.line_start;
                encipher(mon_req, mon_res);
                expected_text.push_back(mon_res);
                progress = 1'b1;
            end
            if (out_ch.valid && out_ch.ready)
            begin
                progress = 1'b1;
                if (expected_text.size() == 0)
                begin
                    $error("result with no request pending: out_byte %h", out_ch.out_byte);
                    error_count++;
                end
                else
                begin
                    mon_exp = expected_text.pop_front();
                    if (out_ch.out_byte !== mon_exp.data)
                    begin
                        $error("out_byte: expected %h, actual %h", mon_exp.data,
                               out_ch.out_byte);
                        error_count++;
                    end
                    if (out_ch.passed_through !== mon_exp.passed)
                    begin
                        $error("passed_through: expected %b, actual %b", mon_exp.passed,
                               out_ch.passed_through);
                        error_count++;
                    end
                end
            end
            quiet_cycles = progress ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no request accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic reg_write(input vig_reg_t r, input logic [63:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(int'(r) * 8);
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic reg_check(input vig_reg_t r);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= APB_ADDR_W'(int'(r) * 8);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== reg_value(r))
        begin
            $error("register %s: expected %h, actual %h", r.name(), reg_value(r), prdata);
            reg_error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // full register set, then read back
    task automatic configure(input vig_mode_t m, input int len, input logic [63:0] k0,
                             input logic [63:0] k1, input logic [63:0] k2,
                             input logic [63:0] k3);
        vig_reg_t r;
        reg_write(REG_MODE, 64'(m));
        reg_write(REG_KEY_LEN, 64'(len));
        reg_write(REG_KEY0, k0);
        reg_write(REG_KEY1, k1);
        reg_write(REG_KEY2, k2);
        reg_write(REG_KEY3, k3);
        r = r.first();
        repeat (r.num())
        begin
            reg_check(r);
            r = r.next();
        end
        @(negedge clk);
    endtask

    task automatic push_text(input logic [7:0] data, input logic line_start);
        text_req_t t;
        t.data       = data;
        t.line_start = line_start;
        pending_text.push_back(t);
    endtask

    // wait until every request is out and the pipeline is empty
    task automatic drain();
        while (pending_text.size() != 0 || in_ch.valid || expected_text.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // mostly text with line breaks, some arbitrary bytes
    function automatic text_req_t random_text();
        text_req_t t;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            t.data = alpha_char($urandom_range(0, SYMBOLS - 1));
        else if (pick < 80)
            t.data = CHAR_NL;
        else if (pick < 85)
            t.data = CHAR_CR;
        else
            t.data = 8'($urandom_range(0, 255));
        t.line_start = ($urandom_range(0, 15) == 0);
        return t;
    endfunction

    // key word: mostly alphabet characters, sometimes all zeros, all ones or junk
    function automatic logic [63:0] random_key_word();
        logic [63:0] w;
        int          pick;
        int          j;
        pick = $urandom_range(0, 7);
        if (pick == 0)
            w = '0;
        else if (pick == 1)
            w = '1;
        else
        begin
            for (j = 0; j < 8; j++)
            begin
                if ($urandom_range(0, 4) == 0)
                    w[8*j +: 8] = 8'($urandom);
                else
                    w[8*j +: 8] = alpha_char($urandom_range(0, SYMBOLS - 1));
            end
        end
        return w;
    endfunction

    initial
    begin
        int        ph;
        int        n;
        int        len;
        vig_mode_t m;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: zero key byte is outside the alphabet and shifts by zero
        push_text("A", 1'b0);
        push_text("|", 1'b0);
        push_text(8'h00, 1'b0);
        push_text(8'hFF, 1'b0);
        push_text(CHAR_NL, 1'b0);
        push_text(CHAR_CR, 1'b0);
        push_text("0", 1'b0);
        push_text(" ", 1'b0);
        drain();

        // three-character key with one junk byte, wraps at both ends of the alphabet
        configure(MODE_ENCRYPT, 3, 64'h0000_0000_0080_617C, '1, '0, random_key_word());
        push_text("|", 1'b0);
        push_text("A", 1'b0);
        push_text("B", 1'b0);
        push_text("C", 1'b0);
        push_text("D", 1'b1);
        push_text(CHAR_NL, 1'b0);
        push_text("E", 1'b0);
        push_text(CHAR_CR, 1'b0);
        push_text("F", 1'b0);
        drain();

        configure(MODE_DECRYPT, 3, 64'h0000_0000_0080_617C, '0, '1, random_key_word());
        push_text("A", 1'b1);
        push_text("A", 1'b0);
        push_text("A", 1'b0);
        push_text("|", 1'b0);
        push_text(8'h7F, 1'b0);
        push_text(CHAR_NL, 1'b1);
        drain();

        // random phases, key length extremes first
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       len = 0;
                1:       len = 63;
                2:       len = KEY_MAX;
                3:       len = 1;
                default: len = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 63))
                                                           : int'($urandom_range(1, KEY_MAX));
            endcase
            m = (ph < 4) ? vig_mode_t'(ph % 2) : vig_mode_t'($urandom_range(0, 1));
            configure(m, len, random_key_word(), random_key_word(), random_key_word(),
                      random_key_word());
            send_no_idle = (ph % 3 == 1);
            recv_no_idle = (ph % 4 == 2) || (ph % 3 == 1 && ph > 6);
            for (n = 0; n < PHASE_ITEMS; n++)
                pending_text.push_back(random_text());
            // long receiver hold-off while requests keep coming
            if (ph == 2 || ph == 7)
                hold_ticket = hold_ticket + 1;
            drain();
        end

        if (error_count == 0 && reg_error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ vigenere_cipher_92_symbol.f @@
rtl/vig_pkg.sv
rtl/vig_if.sv
rtl/vig_cfg.sv
rtl/vig_xform.sv
rtl/vigenere_cipher_92_symbol.sv
tb/tb_vigenere_cipher_92_symbol.sv
